/* rtl/wmcd_pkg.sv */
// Shared types and constants for the windowed mean change detector.
// Used by wmcd_core and the top level; depends on nothing.
package wmcd_pkg;

  // Defaults for the top-level parameters
  localparam int CHANNELS_DEFAULT   = 8;
  localparam int MAX_WINDOW_DEFAULT = 16;

  // Reset values of the configuration registers
  localparam logic [4:0]         WINDOW_LENGTH_RESET  = 5'd10;
  localparam logic signed [15:0] MISSING_MARKER_RESET = -16'sd256;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MISSING_MARKER = 1'b1;

  // Item command codes
  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_OBSERVE = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [2:0]        channel;
    logic signed [15:0] sample;
    logic              end_of_step;
  } item_t;

  typedef struct packed {
    logic [2:0]         channel_out;
    logic signed [15:0] mean;
    logic               changed;
    logic               replan;
  } res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } state_t;

endpackage

/* rtl/wmcd_divider.sv */
// Serial restoring divider: signed sum by unsigned count, truncated toward zero.
// One quotient bit per cycle; depends on nothing but its parameters.
module wmcd_divider #(
  parameter int SUM_W  = 21,
  parameter int FILL_W = 5
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [FILL_W-1:0]       divisor,
  output logic                    done,
  output logic signed [15:0]      quotient
);

  localparam int CNT_W = $clog2(SUM_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [FILL_W-1:0] rem;
  logic [SUM_W-1:0]  quo;
  logic              neg;
  logic [FILL_W-1:0] dvsr;

  logic [SUM_W-1:0]  mag;
  logic [FILL_W:0]   shifted;
  logic [FILL_W:0]   diff;
  logic              ge;
  logic [SUM_W-1:0]  quo_signed;

  assign mag     = dividend[SUM_W-1] ? (SUM_W'(~dividend) + SUM_W'(1)) : SUM_W'(dividend);
  assign shifted = {rem, quo[SUM_W-1]};
  assign ge      = shifted >= {1'b0, dvsr};
  assign diff    = shifted - {1'b0, dvsr};

  assign quo_signed = neg ? (~quo + SUM_W'(1)) : quo;
  assign quotient   = signed'(quo_signed[15:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= mag;
      rem  <= '0;
      neg  <= dividend[SUM_W-1];
      dvsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[FILL_W-1:0] : shifted[FILL_W-1:0];
      quo <= {quo[SUM_W-2:0], ge};
    end
  end

endmodule

/* rtl/wmcd_core.sv */
// Sequencer, per-channel state and sample ring memory of the detector.
// Depends on wmcd_pkg and drives one wmcd_divider.
module wmcd_core
  import wmcd_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEFAULT,
  parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  item_t                            item,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]  eff_window,
  input  logic signed [15:0]               marker,
  output logic                             res_valid,
  input  logic                             res_ready,
  output res_t                             res
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int FILL_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = 16 + SLOT_W + 1;
  localparam int DEPTH  = CHANNELS * MAX_WINDOW;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [CH_W-1:0] ch,
                                                 input logic [SLOT_W-1:0] slot);
    return ADDR_W'(ADDR_W'(ch) * ADDR_W'(MAX_WINDOW)) + ADDR_W'(slot);
  endfunction

  state_t state, state_next;

  // per-channel state
  logic [SLOT_W-1:0]       oldest  [CHANNELS];
  logic [FILL_W-1:0]       fill    [CHANNELS];
  logic signed [SUM_W-1:0] sum     [CHANNELS];
  logic signed [15:0]      mean    [CHANNELS];
  logic [CHANNELS-1:0]     differs;

  // sample ring
  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] rd_data;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ADDR_W-1:0]  mem_raddr;
  logic signed [15:0] mem_wdata;

  // item held for the duration of its work
  item_t              cur;
  logic [CH_W-1:0]    cur_idx;
  logic signed [15:0] res_mean;
  logic               res_changed;

  logic [CH_W-1:0]    in_idx;
  logic               in_ok;

  logic [FILL_W-1:0]       fill_c;
  logic [SLOT_W-1:0]       old_c;
  logic                    full;
  logic [FILL_W:0]         slot_sum;
  logic [SLOT_W-1:0]       slot;
  logic signed [SUM_W-1:0] sum_new;
  logic [FILL_W-1:0]       fill_new;
  logic [SLOT_W-1:0]       old_new;

  logic                    div_start;
  logic                    div_done;
  logic signed [15:0]      div_q;

  assign in_idx = CH_W'(item.channel);
  assign in_ok  = 32'(item.channel) < CHANNELS;

  // ring arithmetic for the update step
  assign fill_c   = fill[cur_idx];
  assign old_c    = oldest[cur_idx];
  assign full     = fill_c >= eff_window;
  assign slot_sum = (FILL_W+1)'(old_c) + (FILL_W+1)'(fill_c);
  assign slot     = (slot_sum >= (FILL_W+1)'(MAX_WINDOW))
                    ? SLOT_W'(slot_sum - (FILL_W+1)'(MAX_WINDOW)) : SLOT_W'(slot_sum);
  assign sum_new  = full ? (sum[cur_idx] - SUM_W'(rd_data) + SUM_W'(cur.sample))
                         : (sum[cur_idx] + SUM_W'(cur.sample));
  assign fill_new = full ? fill_c : fill_c + FILL_W'(1);
  assign old_new  = !full ? old_c
                  : (old_c == SLOT_W'(MAX_WINDOW - 1)) ? '0 : old_c + SLOT_W'(1);

  // oldest entry is fetched while the item is accepted
  assign mem_raddr = addr_of(in_idx, oldest[in_idx]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    res_valid  = 1'b0;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = addr_of(cur_idx, slot);
    mem_wdata  = cur.sample;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (!in_ok) begin
            state_next = ST_DONE;
          end else if (item.cmd == CMD_LOAD) begin
            mem_we     = 1'b1;
            mem_waddr  = addr_of(in_idx, '0);
            mem_wdata  = item.sample;
            state_next = ST_DONE;
          end else if (item.sample == marker) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_UPDATE;
          end
        end
      end
      ST_UPDATE: begin
        mem_we     = 1'b1;
        div_start  = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // per-channel state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        oldest[i] <= '0;
        fill[i]   <= '0;
        sum[i]    <= '0;
        mean[i]   <= '0;
      end
      differs <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item_valid && in_ok && item.cmd == CMD_LOAD) begin
            oldest[in_idx]  <= '0;
            fill[in_idx]    <= FILL_W'(1);
            sum[in_idx]     <= SUM_W'(item.sample);
            mean[in_idx]    <= item.sample;
            differs[in_idx] <= 1'b0;
          end
        end
        ST_UPDATE: begin
          sum[cur_idx]    <= sum_new;
          fill[cur_idx]   <= fill_new;
          oldest[cur_idx] <= old_new;
        end
        ST_DIVIDE: begin
          if (div_done) begin
            mean[cur_idx]    <= div_q;
            differs[cur_idx] <= div_q != mean[cur_idx];
          end
        end
        default: ;
      endcase
    end
  end

  // held item and result payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cur         <= item;
          cur_idx     <= in_idx;
          res_changed <= 1'b0;
          if (!in_ok) begin
            res_mean <= '0;
          end else if (item.cmd == CMD_LOAD) begin
            res_mean <= item.sample;
          end else begin
            res_mean <= mean[in_idx];
          end
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          res_mean    <= div_q;
          res_changed <= div_q != mean[cur_idx];
        end
      end
      default: ;
    endcase
  end

  assign res.channel_out = cur.channel;
  assign res.mean        = res_mean;
  assign res.changed     = res_changed;
  assign res.replan      = cur.end_of_step & (|differs);

  wmcd_divider #(
    .SUM_W  (SUM_W),
    .FILL_W (FILL_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_new),
    .divisor  (fill_new),
    .done     (div_done),
    .quotient (div_q)
  );

endmodule

/* rtl/windowed_mean_change_detector.sv */
// Top level of the windowed mean change detector: stream ports, config
// registers and output register. Depends on wmcd_pkg, wmcd_core, wmcd_divider.
//
// Each channel keeps a ring of up to MAX_WINDOW signed Q8.8 samples with an
// exact running sum, and reports the windowed mean (sum / count, truncated
// toward zero) for every item on a channel below CHANNELS; an item for a
// channel beyond CHANNELS reports a mean of 0. A load item (tuser = 0) seeds
// the channel with one entry; an observe item (tuser = 1) equal to
// missing_marker changes nothing. A per-channel differs bit tracks whether the
// last observation moved the mean, and an item with tlast set reports the OR
// of all differs bits as replan. Timing: the block takes one item at a time.
// An observation that updates the window passes through the update and divide
// states and has its result offered once the serial divider is done; the
// divider retires one quotient bit per cycle over the SUM_W bit sum
// (SUM_W = 17 + log2 MAX_WINDOW). Load items, ignored observations and items
// for a channel beyond CHANNELS have their result offered in the cycle after
// acceptance. A new item is taken once the previous result has moved into the
// output register, so no item is taken while a result waits in the core.
// Window length 0 acts as 1 and values above MAX_WINDOW act as MAX_WINDOW.
// Configuration writes are accepted at any time but are meant for idle
// periods only.
module windowed_mean_change_detector
  import wmcd_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEFAULT,
  parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  // input items
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // [2:0] channel, [18:3] sample, rest zero
  input  logic                 s_tuser,   // [0] cmd
  input  logic                 s_tlast,   // end_of_step
  // result items
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // [2:0] channel_out, [18:3] mean,
                                          // [19] changed, [20] replan, rest zero
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int FILL_W = $clog2(MAX_WINDOW + 1);

  logic [4:0]         window_length;
  logic signed [15:0] missing_marker;
  logic [FILL_W-1:0]  eff_window;

  item_t item;
  res_t  res;
  logic  res_valid;
  logic  res_ready;
  res_t  out_res;

  // config registers, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length  <= WINDOW_LENGTH_RESET;
      missing_marker <= MISSING_MARKER_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_LENGTH:  window_length  <= cfg_data[4:0];
        REG_MISSING_MARKER: missing_marker <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  // clamp window length into 1..MAX_WINDOW
  always_comb begin
    if (window_length == 5'd0) begin
      eff_window = FILL_W'(1);
    end else if (32'(window_length) > MAX_WINDOW) begin
      eff_window = FILL_W'(MAX_WINDOW);
    end else begin
      eff_window = FILL_W'(window_length);
    end
  end

  // unpack input item
  assign item.cmd         = s_tuser;
  assign item.channel     = s_tdata[2:0];
  assign item.sample      = signed'(s_tdata[18:3]);
  assign item.end_of_step = s_tlast;

  wmcd_core #(
    .CHANNELS   (CHANNELS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s_tvalid),
    .item_ready (s_tready),
    .item       (item),
    .eff_window (eff_window),
    .marker     (missing_marker),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // output register: result leaves the core as soon as this slot is free
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {3'b000, out_res.replan, out_res.changed, out_res.mean,
                    out_res.channel_out};

endmodule
